[rtl/ssc_pkg.sv]
// Shared types and constants for the sphere-sphere contact core.
package ssc_pkg;

	localparam int NumAxes   = 3;
	localparam int SqrtSteps = 32;
	localparam int DivSteps  = 31;
	localparam int DivLanes  = 2 * NumAxes;
	// clock edges from the accepting edge to the edge that takes the result
	localparam int Latency   = 69;

	localparam logic [29:0] FallbackReset = 30'd32768;
	localparam logic [14:0] NormOne       = 15'd16384;

	// per-transaction context carried down the pipeline
	typedef struct packed {
		logic [NumAxes-1:0][31:0] pa;
		logic [NumAxes-1:0]       neg;
		logic [NumAxes-1:0][30:0] mag;
		logic [29:0]              ra;
		logic [30:0]              rsum;
		logic                     contact;
	} ctx_t;

	// square root cell payload
	typedef struct packed {
		ctx_t        ctx;
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// divider cell payload: lanes 0..2 normal, 3..5 contact point
	typedef struct packed {
		ctx_t                      ctx;
		logic [31:0]               dist_len;
		logic [DivLanes-1:0][31:0] rem;
		logic [DivLanes-1:0][30:0] num;
		logic [DivLanes-1:0][30:0] quo;
	} div_t;

endpackage

[rtl/ssc_sqrt_cell.sv]
// One restoring square root step: two radicand bits in, one root bit out.
module ssc_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ssc_pkg::sqrt_t in_data,
	output logic          out_valid,
	output ssc_pkg::sqrt_t out_data
);
	import ssc_pkg::*;

	logic [35:0] rem_sh;
	logic [35:0] trial;
	sqrt_t       nxt;
	logic        valid_q;
	sqrt_t       data_q;

	// bring down two bits and try to subtract the trial root
	always_comb begin
		rem_sh = {in_data.rem, in_data.rad[63:62]};
		trial  = {2'b00, in_data.root, 2'b01};
		nxt     = in_data;
		nxt.rad = {in_data.rad[61:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = 34'(rem_sh - trial);
			nxt.root = {in_data.root[30:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh[33:0];
			nxt.root = {in_data.root[30:0], 1'b0};
		end
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

[rtl/ssc_div_cell.sv]
// One restoring division step across all six quotient lanes.
module ssc_div_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  ssc_pkg::div_t in_data,
	output logic         out_valid,
	output ssc_pkg::div_t out_data
);
	import ssc_pkg::*;

	logic [DivLanes-1:0][32:0] rem_sh;
	div_t nxt;
	logic valid_q;
	div_t data_q;

	// shift in the next numerator bit and subtract the distance if it fits
	always_comb begin
		nxt = in_data;
		for (int l = 0; l < DivLanes; l++) begin
			rem_sh[l] = {in_data.rem[l], in_data.num[l][30]};
			nxt.num[l] = {in_data.num[l][29:0], 1'b0};
			if (rem_sh[l] >= {1'b0, in_data.dist_len}) begin
				nxt.rem[l] = 32'(rem_sh[l] - {1'b0, in_data.dist_len});
				nxt.quo[l] = {in_data.quo[l][29:0], 1'b1};
			end else begin
				nxt.rem[l] = rem_sh[l][31:0];
				nxt.quo[l] = {in_data.quo[l][29:0], 1'b0};
			end
		end
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

[rtl/sphere_sphere_contact_core.sv]
// Top level of the sphere-sphere contact core.
//
// Usage: drive the two centers, radii and is_sphere flags and raise start;
// the transaction is taken at an edge where start is high and busy is low.
// busy stays low, so one transaction may be started every cycle.
// Each transaction gives exactly one result: done is high for one cycle
// with colliding, normal, penetration and contact point on their ports,
// and the result is taken at the edge that ends that cycle.
// Throughput: one transaction per cycle. The path is four setup stages
// (capture, difference, squares, sum and compare), a row of 32 square root
// cells, a numerator stage, a row of 31 divider cells that form all six
// quotients in parallel, and a result register.
// The fallback radius is written through cfg_wdata when cfg_we is high; the user must
// write it only while no transaction is in flight, which the block itself does not enforce;
// reset sets it to 0.5. Reset clears all pipeline valid bits and done; in-flight work is dropped.
// The receiver cannot stall: results are presented once and never held.
module sphere_sphere_contact_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [29:0]        cfg_wdata,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_a_z,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] pos_b_z,
	input  logic [29:0]        radius_a,
	input  logic [29:0]        radius_b,
	input  logic               a_is_sphere,
	input  logic               b_is_sphere,
	output logic               done,
	output logic               colliding,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [30:0]        penetration,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);
	import ssc_pkg::*;

	logic [29:0] fallback_q;

	// stage 1: captured transaction
	logic                     valid_s1;
	logic [NumAxes-1:0][31:0] pa_s1;
	logic [NumAxes-1:0][31:0] pb_s1;
	logic [29:0]              ra_s1;
	logic [30:0]              rsum_s1;

	// stage 2: differences
	logic                     valid_s2;
	logic [NumAxes-1:0][31:0] pa_s2;
	logic [NumAxes-1:0]       neg_s2;
	logic [NumAxes-1:0][30:0] mag_s2;
	logic                     far_s2;
	logic [29:0]              ra_s2;
	logic [30:0]              rsum_s2;
	logic [NumAxes-1:0][32:0] diff;
	logic [NumAxes-1:0][32:0] dmag;

	// stage 3: squares
	logic                     valid_s3;
	ctx_t                     ctx_s3;
	logic                     far_s3;
	logic [NumAxes-1:0][61:0] sq_s3;
	logic [61:0]              rsq_s3;

	// stage 4: square root input
	logic        valid_s4;
	sqrt_t       sqrt_s4;
	logic [63:0] dsq;
	ctx_t        ctx_hit;

	logic  [SqrtSteps-1:0] sqrt_valid;
	sqrt_t [SqrtSteps-1:0] sqrt_data;

	// numerator stage
	logic                    valid_s5;
	div_t                    div_s5;
	logic [NumAxes-1:0][61:0] nn;
	logic [NumAxes-1:0][61:0] np;
	logic [NumAxes-1:0][60:0] prod;

	logic [DivSteps-1:0] div_valid;
	div_t [DivSteps-1:0] div_data;

	div_t                     fin;
	logic [NumAxes-1:0][15:0] norm_res;
	logic [NumAxes-1:0][31:0] pt_res;
	logic [NumAxes-1:0][30:0] qn;
	logic [NumAxes-1:0][30:0] qp;
	logic [NumAxes-1:0][14:0] nm;
	logic [NumAxes-1:0][29:0] om;
	logic [NumAxes-1:0][33:0] psum;
	logic [30:0]              pen_res;

	logic               done_q;
	logic               colliding_q;
	logic [NumAxes-1:0][15:0] normal_q;
	logic [30:0]        penetration_q;
	logic [NumAxes-1:0][31:0] point_q;

	assign busy = 1'b0;

	// hold the fallback radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= FallbackReset;
		end else if (cfg_we) begin
			fallback_q <= cfg_wdata;
		end
	end

	// valid bits of the setup stages and the numerator stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= sqrt_valid[SqrtSteps-1];
		end
	end

	// capture the transaction and pick the radii
	always_ff @(posedge clk) begin
		pa_s1   <= {pos_a_z, pos_a_y, pos_a_x};
		pb_s1   <= {pos_b_z, pos_b_y, pos_b_x};
		ra_s1   <= a_is_sphere ? radius_a : fallback_q;
		rsum_s1 <= {1'b0, a_is_sphere ? radius_a : fallback_q}
			+ {1'b0, b_is_sphere ? radius_b : fallback_q};
	end

	// form per-axis differences and magnitudes
	always_comb begin
		for (int a = 0; a < NumAxes; a++) begin
			diff[a] = {pb_s1[a][31], pb_s1[a]} - {pa_s1[a][31], pa_s1[a]};
			dmag[a] = diff[a][32] ? 33'(-diff[a]) : diff[a];
		end
	end

	always_ff @(posedge clk) begin
		pa_s2   <= pa_s1;
		ra_s2   <= ra_s1;
		rsum_s2 <= rsum_s1;
		far_s2  <= (|dmag[0][32:31]) || (|dmag[1][32:31]) || (|dmag[2][32:31]);
		for (int a = 0; a < NumAxes; a++) begin
			neg_s2[a] <= diff[a][32];
			mag_s2[a] <= dmag[a][30:0];
		end
	end

	// square the magnitudes and the radius sum
	always_ff @(posedge clk) begin
		ctx_s3.pa      <= pa_s2;
		ctx_s3.neg     <= neg_s2;
		ctx_s3.mag     <= mag_s2;
		ctx_s3.ra      <= ra_s2;
		ctx_s3.rsum    <= rsum_s2;
		ctx_s3.contact <= 1'b0;
		far_s3         <= far_s2;
		rsq_s3         <= 62'(rsum_s2) * 62'(rsum_s2);
		for (int a = 0; a < NumAxes; a++) begin
			sq_s3[a] <= 62'(mag_s2[a]) * 62'(mag_s2[a]);
		end
	end

	// sum the squares and test for contact
	assign dsq = 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);

	always_comb begin
		ctx_hit         = ctx_s3;
		ctx_hit.contact = !far_s3 && (dsq <= 64'(rsq_s3));
	end

	always_ff @(posedge clk) begin
		sqrt_s4.ctx  <= ctx_hit;
		sqrt_s4.rad  <= dsq;
		sqrt_s4.rem  <= '0;
		sqrt_s4.root <= '0;
	end

	// square root row
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			ssc_sqrt_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(valid_s4), .in_data(sqrt_s4),
				.out_valid(sqrt_valid[k]), .out_data(sqrt_data[k])
			);
		end else begin : g_next
			ssc_sqrt_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(sqrt_valid[k-1]), .in_data(sqrt_data[k-1]),
				.out_valid(sqrt_valid[k]), .out_data(sqrt_data[k])
			);
		end
	end

	// form rounded numerators for both quotients per axis
	always_comb begin
		for (int a = 0; a < NumAxes; a++) begin
			prod[a] = 61'(sqrt_data[SqrtSteps-1].ctx.mag[a])
				* 61'(sqrt_data[SqrtSteps-1].ctx.ra);
			nn[a] = (62'(sqrt_data[SqrtSteps-1].ctx.mag[a]) << 14)
				+ 62'(sqrt_data[SqrtSteps-1].root[31:1]);
			np[a] = {1'b0, prod[a]} + 62'(sqrt_data[SqrtSteps-1].root[31:1]);
		end
	end

	always_ff @(posedge clk) begin
		div_s5.ctx      <= sqrt_data[SqrtSteps-1].ctx;
		div_s5.dist_len <= sqrt_data[SqrtSteps-1].root;
		for (int a = 0; a < NumAxes; a++) begin
			div_s5.rem[a]           <= {1'b0, nn[a][61:31]};
			div_s5.num[a]           <= nn[a][30:0];
			div_s5.quo[a]           <= '0;
			div_s5.rem[a + NumAxes] <= {1'b0, np[a][61:31]};
			div_s5.num[a + NumAxes] <= np[a][30:0];
			div_s5.quo[a + NumAxes] <= '0;
		end
	end

	// divider row
	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		if (j == 0) begin : g_first
			ssc_div_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(valid_s5), .in_data(div_s5),
				.out_valid(div_valid[j]), .out_data(div_data[j])
			);
		end else begin : g_next
			ssc_div_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(div_valid[j-1]), .in_data(div_data[j-1]),
				.out_valid(div_valid[j]), .out_data(div_data[j])
			);
		end
	end

	// clamp, sign and saturate the results
	assign fin     = div_data[DivSteps-1];
	assign pen_res = fin.ctx.rsum - fin.dist_len[30:0];

	always_comb begin
		for (int a = 0; a < NumAxes; a++) begin
			qn[a] = fin.quo[a];
			qp[a] = fin.quo[a + NumAxes];
			nm[a] = (qn[a] > 31'(NormOne)) ? NormOne : qn[a][14:0];
			om[a] = (qp[a] > 31'(fin.ctx.ra)) ? fin.ctx.ra : qp[a][29:0];
			norm_res[a] = fin.ctx.neg[a] ? 16'(-{1'b0, nm[a]}) : {1'b0, nm[a]};
			psum[a] = {{2{fin.ctx.pa[a][31]}}, fin.ctx.pa[a]}
				+ (fin.ctx.neg[a] ? 34'(-{4'b0, om[a]}) : {4'b0, om[a]});
			if (psum[a][33] && !(&psum[a][32:31])) begin
				pt_res[a] = 32'h8000_0000;
			end else if (!psum[a][33] && (|psum[a][32:31])) begin
				pt_res[a] = 32'h7FFF_FFFF;
			end else begin
				pt_res[a] = psum[a][31:0];
			end
		end
	end

	// strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid[DivSteps-1];
		end
	end

	always_ff @(posedge clk) begin
		priority if (!fin.ctx.contact) begin
			colliding_q   <= 1'b0;
			normal_q      <= '0;
			penetration_q <= '0;
			point_q       <= '0;
		end else if (fin.dist_len == '0) begin
			colliding_q   <= 1'b1;
			normal_q      <= {16'd0, {1'b0, NormOne}, 16'd0};
			penetration_q <= fin.ctx.rsum;
			point_q       <= fin.ctx.pa;
		end else begin
			colliding_q   <= 1'b1;
			normal_q      <= norm_res;
			penetration_q <= pen_res;
			point_q       <= pt_res;
		end
	end

	assign done        = done_q;
	assign colliding   = colliding_q;
	assign normal_x    = normal_q[0];
	assign normal_y    = normal_q[1];
	assign normal_z    = normal_q[2];
	assign penetration = penetration_q;
	assign point_x     = point_q[0];
	assign point_y     = point_q[1];
	assign point_z     = point_q[2];
endmodule

[rtl/ssc_checker.sv]
// Port-level checks for the sphere-sphere contact core and their binding.
module ssc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               colliding,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic [30:0]        penetration,
	input logic signed [31:0] point_x
);
	import ssc_pkg::*;

	// every result traces back to a transaction a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without matching transaction");

	// a miss reports all zeros (checked on normal, penetration and point_x)
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !colliding) |-> (normal_x == 16'sd0 && normal_y == 16'sd0
			&& normal_z == 16'sd0 && penetration == 31'd0 && point_x == 32'sd0))
		else $error("non-colliding result not zero");

	// normal components stay within unit range
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && colliding) |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384
			&& normal_y >= -16'sd16384 && normal_y <= 16'sd16384
			&& normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
		else $error("normal out of range");
endmodule

bind sphere_sphere_contact_core ssc_checker u_ssc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.colliding(colliding), .normal_x(normal_x), .normal_y(normal_y),
	.normal_z(normal_z), .penetration(penetration), .point_x(point_x)
);

[dv/tb_top.sv]
// Self-checking testbench for the sphere-sphere contact core.
module tb_top;
	import ssc_pkg::*;

	typedef struct {
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [29:0]        ra, rb;
		logic               sa, sb;
	} pair_t;

	typedef struct {
		logic               hit;
		logic signed [15:0] nx, ny, nz;
		logic [30:0]        pen;
		logic signed [31:0] px, py, pz;
	} contact_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_we = 0;
	logic [29:0] cfg_wdata = '0;
	logic signed [31:0] pos_a_x = 0, pos_a_y = 0, pos_a_z = 0;
	logic signed [31:0] pos_b_x = 0, pos_b_y = 0, pos_b_z = 0;
	logic [29:0] radius_a = 0, radius_b = 0;
	logic a_is_sphere = 0, b_is_sphere = 0;
	logic done, colliding;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [30:0] penetration;
	logic signed [31:0] point_x, point_y, point_z;

	logic [29:0] fallback_model = FallbackReset;
	contact_t expected_contacts[$];
	int errors = 0;
	int idle_cycles = 0;
	int sent = 0;
	int hits_seen = 0;
	bit gaps_on = 1;

	localparam int WatchdogLimit = 2000;

	sphere_sphere_contact_core DUT (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// floor square root of a 64-bit value
	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	// round mag*scale/div half away from zero, clamp to limit
	function automatic logic [63:0] round_ratio(logic [63:0] mag, logic [63:0] scale,
			logic [63:0] dv, logic [63:0] limit);
		logic [63:0] q;
		q = (mag * scale + dv / 2) / dv;
		return (q > limit) ? limit : q;
	endfunction

	function automatic logic signed [31:0] sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > 64'sd2147483647) return 32'sh7fffffff;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		contact_t c;
		longint pa[3], d[3];
		logic [63:0] mg[3], nm, om, dsq, dlen, ra, rb, rsum;
		longint sm;
		c = '{default: 0};
		ra = p.sa ? p.ra : fallback_model;
		rb = p.sb ? p.rb : fallback_model;
		rsum = ra + rb;
		pa[0] = p.ax; pa[1] = p.ay; pa[2] = p.az;
		d[0] = longint'(p.bx) - pa[0];
		d[1] = longint'(p.by) - pa[1];
		d[2] = longint'(p.bz) - pa[2];
		dsq = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = d[i] < 0 ? -d[i] : d[i];
			if (mg[i] >= 64'h80000000) return c;
			dsq += mg[i] * mg[i];
		end
		if (dsq > rsum * rsum) return c;
		c.hit = 1;
		dlen = floor_sqrt(dsq);
		if (dlen == 0) begin
			c.ny = 16'sd16384;
			c.pen = rsum[30:0];
			c.px = 32'(pa[0]); c.py = 32'(pa[1]); c.pz = 32'(pa[2]);
			return c;
		end
		c.pen = 31'(rsum - dlen);
		for (int i = 0; i < 3; i++) begin
			nm = round_ratio(mg[i], 16384, dlen, 16384);
			om = round_ratio(mg[i], ra, dlen, ra);
			sm = d[i] < 0 ? -longint'(om) : longint'(om);
			case (i)
				0: begin c.nx = 16'(d[i] < 0 ? -nm : nm); c.px = sat_add(pa[i], sm); end
				1: begin c.ny = 16'(d[i] < 0 ? -nm : nm); c.py = sat_add(pa[i], sm); end
				default: begin
					c.nz = 16'(d[i] < 0 ? -nm : nm); c.pz = sat_add(pa[i], sm);
				end
			endcase
		end
		return c;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		contact_t e;
		if (arst_n && done) begin
			if (expected_contacts.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = expected_contacts.pop_front();
				if (e.hit) hits_seen++;
				if (colliding !== e.hit) report_mismatch("colliding", colliding, e.hit);
				if (normal_x !== e.nx) report_mismatch("normal_x", normal_x, e.nx);
				if (normal_y !== e.ny) report_mismatch("normal_y", normal_y, e.ny);
				if (normal_z !== e.nz) report_mismatch("normal_z", normal_z, e.nz);
				if (penetration !== e.pen) report_mismatch("penetration", penetration, e.pen);
				if (point_x !== e.px) report_mismatch("point_x", point_x, e.px);
				if (point_y !== e.py) report_mismatch("point_y", point_y, e.py);
				if (point_z !== e.pz) report_mismatch("point_z", point_z, e.pz);
			end
		end
	end

	// end the run when nothing is accepted and no result arrives for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog expired");
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_pair(pair_t p);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		pos_a_x <= p.ax; pos_a_y <= p.ay; pos_a_z <= p.az;
		pos_b_x <= p.bx; pos_b_y <= p.by; pos_b_z <= p.bz;
		radius_a <= p.ra; radius_b <= p.rb;
		a_is_sphere <= p.sa; b_is_sphere <= p.sb;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_contacts.push_back(predict_contact(p));
		sent++;
	endtask

	task automatic drain_and_wait;
		start <= 0;
		@(posedge clk);
		while (expected_contacts.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic write_fallback(logic [29:0] v);
		drain_and_wait();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		fallback_model = v;
	endtask

	function automatic pair_t make_pair(logic signed [31:0] ax, ay, az, bx, by, bz,
			logic [29:0] ra, rb, logic sa, sb);
		pair_t p;
		p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
		p.ra = ra; p.rb = rb; p.sa = sa; p.sb = sb;
		return p;
	endfunction

	// mostly near pairs with small offsets so contact is common
	function automatic pair_t random_pair();
		pair_t p;
		int mode;
		logic signed [31:0] spread;
		mode = $urandom_range(0, 9);
		p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
		p.ra = 30'($urandom); p.rb = 30'($urandom);
		p.sa = $urandom_range(0, 3) != 0;
		p.sb = $urandom_range(0, 3) != 0;
		if (mode < 6) begin
			p.ra = 30'($urandom_range(0, 1 << (2 + $urandom_range(0, 27))));
			p.rb = 30'($urandom_range(0, 1 << (2 + $urandom_range(0, 27))));
			spread = (p.ra + p.rb) / 2 + 1;
			p.bx = p.ax + $signed($urandom_range(0, 2 * spread)) - spread;
			p.by = p.ay + $signed($urandom_range(0, 2 * spread)) - spread;
			p.bz = p.az + $signed($urandom_range(0, 2 * spread)) - spread;
		end else if (mode < 7) begin
			p.bx = p.ax; p.by = p.ay; p.bz = p.az;
		end else begin
			p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
		end
		return p;
	endfunction

	task automatic test_directed;
		logic signed [31:0] mx, mn;
		logic [29:0] rmax;
		mx = 32'sh7fffffff; mn = 32'sh80000000; rmax = 30'h3fffffff;
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(5, -7, 9, 5, -7, 9, rmax, rmax, 1, 1));
		send_pair(make_pair(0, 0, 0, 65536, 0, 0, 32768, 32768, 1, 1));
		send_pair(make_pair(0, 0, 0, 65537, 0, 0, 32768, 32768, 1, 1));
		send_pair(make_pair(0, 0, 0, 0, 0, -65536, 0, 0, 0, 0));
		send_pair(make_pair(mn, mn, mn, mx, mx, mx, rmax, rmax, 1, 1));
		send_pair(make_pair(mn, 0, 0, -1, 0, 0, rmax, rmax, 1, 1));
		send_pair(make_pair(mx, mx, mx, mx - rmax, mx, mx, rmax, rmax, 1, 1));
		send_pair(make_pair(mx, mx, mx, mx - 100, mx - 100, mx - 100, rmax, rmax, 1, 1));
		send_pair(make_pair(mn, mn, mn, mn + 100, mn + 100, mn + 100, rmax, rmax, 1, 1));
		send_pair(make_pair(mn + 5, mn, mn, mn, mn, mn, rmax, 0, 1, 1));
		send_pair(make_pair(0, 0, 0, 3, 4, 12, 13, 0, 1, 1));
		send_pair(make_pair(-3, -4, -12, 0, 0, 0, 1, 12, 1, 0));
		send_pair(make_pair(0, 0, 0, 1, 1, 1, 0, 1, 1, 1));
		send_pair(make_pair(100, 200, 300, -500, 700, -900, rmax, 5, 0, 1));
		send_pair(make_pair(mx, mn, 0, mx, mn, 1, 1, 0, 1, 1));
	endtask

	task automatic test_random(int count);
		repeat (count) send_pair(random_pair());
	endtask

	task automatic test_fallback_settings;
		write_fallback(30'h3fffffff);
		test_directed();
		test_random(300);
		write_fallback(0);
		test_directed();
		test_random(300);
		write_fallback(30'($urandom));
		test_random(300);
		write_fallback(FallbackReset);
	endtask

	task automatic test_back_to_back;
		gaps_on = 0;
		test_random(400);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_fallback_settings();
		test_back_to_back();
		drain_and_wait();
		$display("sent %0d pairs over four fallback radius settings, %0d contacts",
			sent, hits_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

[files.f]
rtl/ssc_pkg.sv
rtl/ssc_sqrt_cell.sv
rtl/ssc_div_cell.sv
rtl/sphere_sphere_contact_core.sv
rtl/ssc_checker.sv
dv/tb_top.sv
